/* rtl/core/lcac_pkg.sv */
`default_nettype none

package lcac_pkg;

    localparam int ENTRIES_DEF     = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int AGE_WIDTH_DEF   = 32;

    localparam int KEY_W = 17;
    localparam int CNT_W = 32;
    localparam int RES_W = 32;

    localparam logic [KEY_W-1:0] MAX_KEY_RST = 17'd100000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic upd;
        logic wr;
    } t_cell_cmd;

endpackage

`default_nettype wire

/* rtl/core/lcac_cell.sv */
`default_nettype none

module lcac_cell
    import lcac_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int AGE_WIDTH   = AGE_WIDTH_DEF,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [KEY_W-1:0]       i_key,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire t_cell_cmd              i_cmd,
    input  wire logic [IDX_W-1:0]       i_touch_idx,
    output logic                        o_match,
    output logic [VALUE_WIDTH-1:0]      o_value,
    input  wire logic [AGE_WIDTH-1:0]   i_best_age,
    input  wire logic [IDX_W-1:0]       i_best_idx,
    output logic [AGE_WIDTH-1:0]        o_best_age,
    output logic [IDX_W-1:0]            o_best_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                   r_valid;
    logic [KEY_W-1:0]       r_key;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [AGE_WIDTH-1:0]   r_age;
    logic [AGE_WIDTH-1:0]   r_best_age;
    logic [IDX_W-1:0]       r_best_idx;
    logic                   w_touched;
    logic                   w_older;

    assign w_touched = (i_touch_idx == MY_IDX);
    assign w_older   = r_valid && (r_age > i_best_age);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.upd && i_cmd.wr && w_touched) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            if (w_touched) begin
                r_age <= '0;
                if (i_cmd.wr) begin
                    r_key   <= i_key;
                    r_value <= i_value;
                end
            end else if (r_valid && (r_age != '1)) begin
                r_age <= r_age + 1'b1;
            end
        end
    end

    // running oldest entry handed down the row
    always_ff @(posedge i_clk) begin
        if (w_older) begin
            r_best_age <= r_age;
            r_best_idx <= MY_IDX;
        end else begin
            r_best_age <= i_best_age;
            r_best_idx <= i_best_idx;
        end
    end

    assign o_match    = r_valid && (r_key == i_key);
    assign o_value    = r_value;
    assign o_best_age = r_best_age;
    assign o_best_idx = r_best_idx;

endmodule

`default_nettype wire

/* rtl/core/lru_cache_age_counters_top.sv */
`default_nettype none

// Fully associative LRU cache in a row of ENTRIES cells, each holding one entry
// with its key, value and saturating age. An item is taken when start is high
// and busy is low. Its result appears on the o_ ports for one cycle with
// o_result_strobe, registered from the update state; the receiver cannot stall
// it and must take it then. A key above the configured limit passes through
// the match and update states only. Any other item (hit or cacheable miss)
// also runs the scan state: after the ages change, the oldest-entry search
// walks the row of cells one cell per cycle to find the next replacement slot.
// The limit register may be written only while busy is low.

module lru_cache_age_counters_top
    import lcac_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int AGE_WIDTH   = AGE_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [KEY_W-1:0] i_request_key,
    input  wire logic [RES_W-1:0] i_downstream_value,
    input  wire logic             i_cfg_we,
    input  wire logic [KEY_W-1:0] i_cfg_data,
    output logic                  o_result_strobe,
    output logic [RES_W-1:0]      o_result_value,
    output logic                  o_hit,
    output logic [CNT_W-1:0]      o_request_count,
    output logic [CNT_W-1:0]      o_hit_count,
    output logic [CNT_W-1:0]      o_miss_count
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);

    t_state                 r_state;
    t_state                 n_state;

    logic [KEY_W-1:0]       r_max_key;
    logic [KEY_W-1:0]       r_key;
    logic [VALUE_WIDTH-1:0] r_dval;
    logic                   r_cacheable;
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [VALUE_WIDTH-1:0] r_hit_val;
    logic [FILL_W-1:0]      r_fill;
    logic [IDX_W-1:0]       r_victim;
    logic [FILL_W-1:0]      r_scan_cnt;
    logic [CNT_W-1:0]       r_req_cnt;
    logic [CNT_W-1:0]       r_hit_cnt;
    logic [CNT_W-1:0]       r_miss_cnt;
    logic                   r_strobe;
    logic [RES_W-1:0]       r_result;
    logic                   r_hit_out;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_emit;
    logic                   w_scan_done;
    t_cell_cmd              w_cmd;
    logic [IDX_W-1:0]       w_touch_idx;
    logic [ENTRIES-1:0]     w_match;
    logic [VALUE_WIDTH-1:0] w_val [ENTRIES];
    logic [AGE_WIDTH-1:0]   w_best_age [ENTRIES+1];
    logic [IDX_W-1:0]       w_best_idx [ENTRIES+1];
    logic                   w_any_match;
    logic [IDX_W-1:0]       w_match_idx;
    logic [VALUE_WIDTH-1:0] w_match_val;
    logic [63:0]            w_dval_wide;
    logic [63:0]            w_res_wide;

    assign w_accept    = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);
    assign w_full      = (r_fill == FILL_W'(ENTRIES));
    assign w_scan_done = (r_scan_cnt == FILL_W'(ENTRIES));
    assign w_dval_wide = {32'b0, i_downstream_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_cmd       = '0;
        w_emit      = 1'b0;
        w_touch_idx = r_victim;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                w_emit    = 1'b1;
                w_cmd.upd = r_hit || r_cacheable;
                w_cmd.wr  = !r_hit && r_cacheable;
                if (r_hit) begin
                    w_touch_idx = r_hit_idx;
                end else if (!w_full) begin
                    w_touch_idx = r_fill[IDX_W-1:0];
                end
                n_state = w_cmd.upd ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // one-hot match: stored keys are unique among valid entries
    always_comb begin
        w_any_match = 1'b0;
        w_match_idx = '0;
        w_match_val = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_any_match = 1'b1;
                w_match_idx = w_match_idx | IDX_W'(i);
                w_match_val = w_match_val | w_val[i];
            end
        end
    end

    assign w_res_wide = r_hit ? 64'(r_hit_val) : 64'(r_dval);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_key  <= MAX_KEY_RST;
            r_fill     <= '0;
            r_victim   <= '0;
            r_req_cnt  <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= w_emit;
            if (i_cfg_we) begin
                r_max_key <= i_cfg_data;
            end
            if (w_emit) begin
                if (r_req_cnt != '1) begin
                    r_req_cnt <= r_req_cnt + 1'b1;
                end
                if (r_hit) begin
                    if (r_hit_cnt != '1) begin
                        r_hit_cnt <= r_hit_cnt + 1'b1;
                    end
                end else if (r_miss_cnt != '1) begin
                    r_miss_cnt <= r_miss_cnt + 1'b1;
                end
            end
            if (w_cmd.wr && !w_full) begin
                r_fill <= r_fill + 1'b1;
            end
            if ((r_state == ST_SCAN) && w_scan_done) begin
                r_victim <= w_best_idx[ENTRIES];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key       <= i_request_key;
            r_dval      <= w_dval_wide[VALUE_WIDTH-1:0];
            r_cacheable <= (i_request_key <= r_max_key);
        end
        if (r_state == ST_MATCH) begin
            r_hit     <= r_cacheable && w_any_match;
            r_hit_idx <= w_match_idx;
            r_hit_val <= w_match_val;
        end
        if (r_state == ST_UPDATE) begin
            r_scan_cnt <= '0;
        end else if (r_state == ST_SCAN) begin
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
        if (w_emit) begin
            r_result  <= w_res_wide[RES_W-1:0];
            r_hit_out <= r_hit;
        end
    end

    assign w_best_age[0] = '0;
    assign w_best_idx[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lcac_cell #(
            .ENTRIES     (ENTRIES),
            .VALUE_WIDTH (VALUE_WIDTH),
            .AGE_WIDTH   (AGE_WIDTH),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_value     (r_dval),
            .i_cmd       (w_cmd),
            .i_touch_idx (w_touch_idx),
            .o_match     (w_match[g]),
            .o_value     (w_val[g]),
            .i_best_age  (w_best_age[g]),
            .i_best_idx  (w_best_idx[g]),
            .o_best_age  (w_best_age[g+1]),
            .o_best_idx  (w_best_idx[g+1])
        );
    end

    assign o_result_strobe = r_strobe;
    assign o_result_value  = r_result;
    assign o_hit           = r_hit_out;
    assign o_request_count = r_req_cnt;
    assign o_hit_count     = r_hit_cnt;
    assign o_miss_count    = r_miss_cnt;

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import lcac_pkg::*;

    localparam int ENTRIES = ENTRIES_DEF;
    localparam int KEY_MAX = (1 << KEY_W) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [AGE_WIDTH_DEF-1:0] AGE_MAX = '1;

    typedef struct {
        logic [RES_W-1:0] value;
        logic             hit;
        logic [CNT_W-1:0] requests;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
    } t_lookup;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [KEY_W-1:0] i_request_key = '0;
    logic [RES_W-1:0] i_downstream_value = '0;
    logic             i_cfg_we = 1'b0;
    logic [KEY_W-1:0] i_cfg_data = '0;
    logic             o_result_strobe;
    logic [RES_W-1:0] o_result_value;
    logic             o_hit;
    logic [CNT_W-1:0] o_request_count;
    logic [CNT_W-1:0] o_hit_count;
    logic [CNT_W-1:0] o_miss_count;

    lru_cache_age_counters_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_request_key      (i_request_key),
        .i_downstream_value (i_downstream_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .o_result_strobe    (o_result_strobe),
        .o_result_value     (o_result_value),
        .o_hit              (o_hit),
        .o_request_count    (o_request_count),
        .o_hit_count        (o_hit_count),
        .o_miss_count       (o_miss_count)
    );

    // cache shadow state
    logic [KEY_W-1:0]         key_limit = MAX_KEY_RST;
    bit                       cache_valid [ENTRIES];
    logic [KEY_W-1:0]         cache_key [ENTRIES];
    logic [RES_W-1:0]         cache_data [ENTRIES];
    logic [AGE_WIDTH_DEF-1:0] cache_age [ENTRIES];
    int                       filled = 0;
    int                       evict_slot = 0;
    bit [CNT_W-1:0]           n_requests;
    bit [CNT_W-1:0]           n_hits;
    bit [CNT_W-1:0]           n_misses;

    t_lookup pending_lookups [$];
    t_lookup want;
    int      fail_count = 0;
    int      n_uncached = 0;
    int      n_evictions = 0;
    int      n_limit_writes = 0;
    int      n_items = 0;
    bit      steady_traffic = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic t_lookup predict_lookup(input logic [KEY_W-1:0] key,
                                               input logic [RES_W-1:0] dval);
        t_lookup                  r;
        bit                       cacheable;
        bit                       found;
        int                       slot;
        int                       pick;
        logic [AGE_WIDTH_DEF-1:0] oldest;
        cacheable = (key <= key_limit);
        found = 1'b0;
        slot = 0;
        n_requests = bump(n_requests);
        if (cacheable) begin
            for (int s = 0; s < ENTRIES; s++) begin
                if (!found && cache_valid[s] && cache_key[s] == key) begin
                    found = 1'b1;
                    slot = s;
                end
            end
        end
        if (found) begin
            n_hits = bump(n_hits);
            r.value = cache_data[slot];
        end else begin
            n_misses = bump(n_misses);
            r.value = dval;
            if (!cacheable) begin
                n_uncached++;
            end else begin
                if (filled < ENTRIES) begin
                    slot = filled;
                    filled++;
                end else begin
                    slot = evict_slot;
                    n_evictions++;
                end
                cache_valid[slot] = 1'b1;
                cache_key[slot] = key;
                cache_data[slot] = dval;
                cache_age[slot] = '0;
            end
        end
        if (found || cacheable) begin
            oldest = '0;
            pick = 0;
            for (int s = 0; s < ENTRIES; s++) begin
                if (cache_valid[s]) begin
                    if (s == slot) begin
                        cache_age[s] = '0;
                    end else begin
                        if (cache_age[s] != AGE_MAX) cache_age[s]++;
                        if (cache_age[s] > oldest) begin
                            oldest = cache_age[s];
                            pick = s;
                        end
                    end
                end
            end
            evict_slot = pick;
        end
        r.hit = found;
        r.requests = n_requests;
        r.hits = n_hits;
        r.misses = n_misses;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_traffic) return 0;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 30);
        return $urandom_range(31, 150);
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 10) $display("%s", msg);
        fail_count++;
    endtask

    task automatic send_item(input logic [KEY_W-1:0] key, input logic [RES_W-1:0] dval);
        int gap;
        start <= 1'b1;
        i_request_key <= key;
        i_downstream_value <= dval;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_lookups.push_back(predict_lookup(key, dval));
        n_items++;
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            i_request_key <= KEY_W'($urandom);
            i_downstream_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off new items until every result is back and the block is idle
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_lookups.size() != 0 || busy !== 1'b0);
    endtask

    task automatic set_key_limit(input logic [KEY_W-1:0] lim);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        key_limit = lim;
        n_limit_writes++;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_key_extremes();
        send_item('0, '0);
        send_item('0, '1);
        send_item(MAX_KEY_RST, '1);
        send_item(MAX_KEY_RST + 1'b1, 32'h5a5a_a5a5);
        send_item('1, 32'h8000_0001);
        send_item(MAX_KEY_RST, '0);
        send_item(MAX_KEY_RST + 1'b1, 32'h0000_0001);
        send_item(17'h0aaaa, $urandom);
        send_item(17'h15555, $urandom);
    endtask

    task automatic test_limit_extremes();
        set_key_limit('1);
        send_item('1, $urandom);
        send_item('1, $urandom);
        set_key_limit('0);
        send_item('1, $urandom);
        send_item('0, $urandom);
        send_item(17'd1, $urandom);
        set_key_limit(MAX_KEY_RST);
        send_item(17'h0aaaa, $urandom);
    endtask

    task automatic test_fill_and_evict();
        for (int i = 0; i < 70; i++) send_item(17'(1000 + i), $urandom);
        for (int i = 0; i < 10; i++) send_item(17'(1000 + 6 * i), $urandom);
        for (int i = 0; i < 10; i++) send_item(17'(2000 + i), $urandom);
    endtask

    // entries above a lowered limit must still age and get evicted
    task automatic test_lowered_limit_eviction();
        set_key_limit('1);
        for (int i = 0; i < 20; i++) send_item(17'(120000 + i), $urandom);
        set_key_limit(17'd50000);
        for (int i = 0; i < 70; i++) begin
            send_item(17'(30000 + i), $urandom);
            if (i % 10 == 0) send_item(17'(120000 + i / 10), $urandom);
        end
        set_key_limit(MAX_KEY_RST);
    endtask

    task automatic test_random_traffic();
        logic [KEY_W-1:0] pool [96];
        logic [KEY_W-1:0] recent [8];
        logic [KEY_W-1:0] key;
        logic [RES_W-1:0] dval;
        int               r;
        for (int i = 0; i < 8; i++) recent[i] = '0;
        for (int seg = 0; seg < 9; seg++) begin
            case (seg)
                0: set_key_limit('1);
                1: set_key_limit('0);
                2: set_key_limit(17'($urandom_range(0, 200)));
                default: set_key_limit(KEY_W'($urandom));
            endcase
            steady_traffic = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 96; i++) begin
                pool[i] = ($urandom_range(0, 9) < 8) ? 17'($urandom_range(0, key_limit))
                                                      : 17'($urandom_range(0, KEY_MAX));
            end
            for (int n = 0; n < 100; n++) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    key = pool[$urandom_range(0, 95)];
                end else if (r < 75) begin
                    key = recent[$urandom_range(0, 7)];
                end else if (r < 88 || key_limit == KEY_MAX) begin
                    key = KEY_W'($urandom);
                end else begin
                    key = 17'($urandom_range(int'(key_limit) + 1, KEY_MAX));
                end
                r = $urandom_range(0, 99);
                dval = (r < 5) ? '0 : (r < 10) ? '1 : $urandom;
                recent[n % 8] = key;
                send_item(key, dval);
            end
        end
        steady_traffic = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (o_result_strobe === 1'b1) begin
            if (pending_lookups.size() == 0) begin
                note_failure("result with no request outstanding");
            end else begin
                want = pending_lookups.pop_front();
                if (o_result_value !== want.value || o_hit !== want.hit
                        || o_request_count !== want.requests || o_hit_count !== want.hits
                        || o_miss_count !== want.misses) begin
                    note_failure($sformatf({"mismatch: exp value=%h hit=%b req=%0d hits=%0d ",
                        "miss=%0d, got value=%h hit=%b req=%0d hits=%0d miss=%0d"},
                        want.value, want.hit, want.requests, want.hits, want.misses,
                        o_result_value, o_hit, o_request_count, o_hit_count,
                        o_miss_count));
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_rst_n && start && busy === 1'b0) || o_result_strobe === 1'b1) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_key_extremes();
        test_limit_extremes();
        test_fill_and_evict();
        test_lowered_limit_eviction();
        test_random_traffic();
        drain_results();
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (pending_lookups.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_lookups.size()));
        end
        $display("ran %0d requests: %0d hits, %0d misses, %0d above the key limit",
                 n_items, n_hits, n_misses, n_uncached);
        $display("%0d lru evictions, %0d key limit writes, %0d failures",
                 n_evictions, n_limit_writes, fail_count);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
